/* rtl/lds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levinson-Durbin solver package
// Shared widths, fixed-point constants and the divider request/response types.
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int MAX_ORDER_DEF = 16;

  localparam int ORDER_W  = 5;
  localparam int CORR_W   = 24;
  localparam int COEF_W   = 32;
  localparam int ENERGY_W = 48;
  localparam int ACC_W    = 64;
  localparam int MAG_W    = ACC_W - 1;
  localparam int QUO_W    = COEF_W - 1;

  localparam int FRAC_SHIFT = 27;

  // integer quotient bits first, then fractional bits
  localparam int DIV_INT_STEPS = 7;
  localparam int DIV_STEPS     = QUO_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(10);

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/levinson_durbin_lpc_solver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levinson-Durbin LPC solver core
// Collects r[0..order] and solves for the predictor and reflection coefficients.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while a frame is loading; the
//   last value of a frame starts the solve and input stalls until all results
//   have been handed to the output register.
// Solve: per stage i a MAC pass over j = 1..i-1, a bit-serial divide, an update
//   and copy pass and the energy update; then each result is read and loaded into
//   the output register. The single coefficient memory port and the divider set its pace.
// Reset: control, order (10) and energy clear; memories hold no reset value.
// ----------------------------------------------------------------------------
module levinson_durbin_lpc_solver_core #(
  parameter int MAX_ORDER = lds_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: prediction order
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lds_pkg::ORDER_W-1:0]        order_i,
  // autocorrelation input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [lds_pkg::CORR_W-1:0]  corr_value_i,
  // coefficient results
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lds_pkg::ORDER_W-1:0]        coef_index_o,
  output logic signed [lds_pkg::COEF_W-1:0]  coef_value_o,
  output logic signed [lds_pkg::COEF_W-1:0]  reflection_o,
  output logic                               status_o,
  output logic                               last_result_o
);

  localparam int DEPTH  = MAX_ORDER + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int COEF_W = lds_pkg::COEF_W;
  localparam int CORR_W = lds_pkg::CORR_W;
  localparam int ACC_W  = lds_pkg::ACC_W;
  localparam int E_W    = lds_pkg::ENERGY_W;
  localparam int MUL_W  = COEF_W + 1;
  localparam int FAC_W  = lds_pkg::FRAC_SHIFT + 1;
  localparam int LOP_W  = 16 + FAC_W;
  localparam int DIF_W  = COEF_W + 6;
  localparam int FS     = lds_pkg::FRAC_SHIFT;

  typedef enum logic [4:0] {
    S_LOAD,
    S_STAGE,
    S_RINIT,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_KWR,
    S_UPD_RA,
    S_UPD_RB,
    S_UPD_WR,
    S_CP_RD,
    S_CP_WR,
    S_KCOEF,
    S_EN_SQ,
    S_EN_FAC,
    S_EN_MUL,
    S_EN_UPD,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  // Coefficient state lives in four single-port synchronous memories.
  logic signed [CORR_W-1:0] corr_mem    [DEPTH];
  logic signed [COEF_W-1:0] coef_mem    [DEPTH];
  logic signed [COEF_W-1:0] scratch_mem [DEPTH];
  logic signed [COEF_W-1:0] reflect_mem [DEPTH];

  state_e                   state_q;
  logic [lds_pkg::ORDER_W-1:0] order_q;
  logic [IDX_W-1:0]         load_cnt_q;
  logic [IDX_W-1:0]         i_q;
  logic [IDX_W-1:0]         j_q;
  logic signed [CORR_W-1:0] r0_q;
  logic [E_W-1:0]           energy_q;
  logic                     failed_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_q;
  logic [LOP_W-1:0]         lo_prod_q;
  logic [FAC_W-1:0]         fac_q;
  logic signed [COEF_W-1:0] k_q;

  // registered memory read data
  logic signed [CORR_W-1:0] corr_rd_q;
  logic signed [COEF_W-1:0] coef_rd_q;
  logic signed [COEF_W-1:0] scr_rd_q;
  logic signed [COEF_W-1:0] refl_rd_q;

  // output register
  logic                     out_valid_q;
  logic [lds_pkg::ORDER_W-1:0] coef_index_q;
  logic signed [COEF_W-1:0] coef_value_q;
  logic signed [COEF_W-1:0] reflection_q;
  logic                     status_q;
  logic                     last_q;

  logic [IDX_W-1:0]         ord;
  logic                     in_acc;
  logic                     out_free;
  logic [IDX_W-1:0]         i_minus_j;
  logic                     j_last;

  logic [IDX_W-1:0]         corr_ra;
  logic [IDX_W-1:0]         coef_ra;
  logic                     corr_we;
  logic                     coef_we;
  logic                     scr_we;
  logic                     refl_we;
  logic [IDX_W-1:0]         coef_wa;
  logic signed [COEF_W-1:0] coef_wd;
  logic signed [COEF_W-1:0] refl_wd;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [COEF_W-1:0]         k_mag;

  logic signed [DIF_W-1:0]  upd_diff;
  logic signed [COEF_W-1:0] upd_sat;
  logic signed [COEF_W-1:0] neg_coef;
  logic [ACC_W-1:0]         e_sum;

  lds_pkg::div_req_t div_req;
  lds_pkg::div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Effective order: zero acts as one, anything above MAX_ORDER clamps.
  // --------------------------------------------------------------------------
  always_comb begin
    if (order_q == '0) begin
      ord = IDX_W'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      ord = IDX_W'(MAX_ORDER);
    end else begin
      ord = IDX_W'(order_q);
    end
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign i_minus_j = i_q - j_q;
  assign j_last    = (j_q == i_q - 1'b1);

  assign in_stall_o  = (state_q != S_LOAD);
  // hold the order write off while an input transaction is being taken
  assign cfg_ready_o = !in_acc;

  // --------------------------------------------------------------------------
  // Memory address and write-enable steering by sequencer state.
  // --------------------------------------------------------------------------
  always_comb begin
    corr_ra = '0;
    coef_ra = '0;
    corr_we = 1'b0;
    coef_we = 1'b0;
    scr_we  = 1'b0;
    refl_we = 1'b0;
    coef_wa = i_q;
    coef_wd = k_q;
    refl_wd = k_q;
    unique case (state_q)
      S_LOAD:    corr_we = in_acc;
      S_STAGE: begin
        corr_ra = i_q;
        if (failed_q) begin
          // dead stage: coefficient and reflection both read as zero
          coef_we = 1'b1;
          refl_we = 1'b1;
          coef_wd = '0;
          refl_wd = '0;
        end
      end
      S_MAC_RD: begin
        coef_ra = j_q;
        corr_ra = i_minus_j;
      end
      S_KWR:     refl_we = 1'b1;
      S_UPD_RA:  coef_ra = i_minus_j;
      S_UPD_RB:  coef_ra = j_q;
      S_UPD_WR:  scr_we  = 1'b1;
      S_CP_WR: begin
        coef_we = 1'b1;
        coef_wa = j_q;
        coef_wd = scr_rd_q;
      end
      S_KCOEF:   coef_we = 1'b1;
      S_EMIT_RD: coef_ra = i_q;
      S_EMIT_LD: coef_ra = i_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (corr_we) begin
      corr_mem[load_cnt_q] <= corr_value_i;
    end
    corr_rd_q <= corr_mem[corr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    coef_rd_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scratch_mem[j_q] <= upd_sat;
    end
    scr_rd_q <= scratch_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (refl_we) begin
      reflect_mem[i_q] <= refl_wd;
    end
    refl_rd_q <= reflect_mem[coef_ra];
  end

  // --------------------------------------------------------------------------
  // Shared multiplier, product registered in prod_q.
  // --------------------------------------------------------------------------
  assign k_mag = k_q[COEF_W-1] ? COEF_W'(-k_q) : k_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAC_MUL: begin
        mul_a = MUL_W'(coef_rd_q);
        mul_b = MUL_W'(corr_rd_q);
      end
      S_UPD_RB: begin
        mul_a = MUL_W'(k_q);
        mul_b = MUL_W'(coef_rd_q);
      end
      S_EN_SQ: begin
        mul_a = $signed({1'b0, k_mag});
        mul_b = $signed({1'b0, k_mag});
      end
      S_EN_MUL: begin
        mul_a = $signed({1'b0, energy_q[E_W-1:16]});
        mul_b = $signed(MUL_W'(fac_q));
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // A[j] - floor(k * A[i-j] / 2^27), clamped to 32 bits
  always_comb begin
    upd_diff = DIF_W'(coef_rd_q) - DIF_W'(prod_q >>> FS);
    if (upd_diff > DIF_W'(lds_pkg::COEF_MAX)) begin
      upd_sat = lds_pkg::COEF_MAX;
    end else if (upd_diff < DIF_W'(lds_pkg::COEF_MIN)) begin
      upd_sat = lds_pkg::COEF_MIN;
    end else begin
      upd_sat = COEF_W'(upd_diff);
    end
  end

  assign neg_coef = (coef_rd_q == lds_pkg::COEF_MIN) ? lds_pkg::COEF_MAX : -coef_rd_q;
  assign e_sum    = ACC_W'(prod_q) + ACC_W'(lo_prod_q >> 16);

  assign div_req.start = (state_q == S_DIV_GO);
  assign div_req.num   = acc_q;

  lds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  (energy_q),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer: load, per-stage MAC / divide / update / copy / energy, emit.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      order_q     <= lds_pkg::ORDER_RESET;
      load_cnt_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      energy_q    <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the output transaction once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT_LD)) begin
        out_valid_q <= 1'b0;
      end

      // any order write restarts frame loading; a solve already running is not aborted
      if (cfg_valid_i && cfg_ready_o) begin
        order_q    <= order_i;
        load_cnt_q <= '0;
      end

      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt_q == '0) begin
              r0_q <= corr_value_i;
            end
            if (load_cnt_q < ord) begin
              load_cnt_q <= load_cnt_q + 1'b1;
            end else begin
              load_cnt_q <= '0;
              i_q        <= IDX_W'(1);
              energy_q   <= {r0_q, {(E_W-CORR_W){1'b0}}};
              failed_q   <= (r0_q <= 0);
              state_q    <= S_STAGE;
            end
          end
        end
        S_STAGE: begin
          state_q <= failed_q ? S_NEXT : S_RINIT;
        end
        S_RINIT: begin
          acc_q <= ACC_W'(corr_rd_q) <<< FS;
          j_q   <= IDX_W'(1);
          state_q <= (i_q == IDX_W'(1)) ? S_DIV_GO : S_MAC_RD;
        end
        S_MAC_RD:  state_q <= S_MAC_MUL;
        S_MAC_MUL: begin
          prod_q  <= ACC_W'(mul_p);
          state_q <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          acc_q <= acc_q - prod_q;
          if (j_last) begin
            state_q <= S_DIV_GO;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_MAC_RD;
          end
        end
        S_DIV_GO:  state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            k_q     <= div_rsp.quo;
            state_q <= S_KWR;
          end
        end
        S_KWR: begin
          j_q     <= IDX_W'(1);
          state_q <= (i_q == IDX_W'(1)) ? S_KCOEF : S_UPD_RA;
        end
        S_UPD_RA:  state_q <= S_UPD_RB;
        S_UPD_RB: begin
          prod_q  <= ACC_W'(mul_p);
          state_q <= S_UPD_WR;
        end
        S_UPD_WR: begin
          if (j_last) begin
            j_q     <= IDX_W'(1);
            state_q <= S_CP_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_UPD_RA;
          end
        end
        S_CP_RD:   state_q <= S_CP_WR;
        S_CP_WR: begin
          if (j_last) begin
            state_q <= S_KCOEF;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_CP_RD;
          end
        end
        S_KCOEF:   state_q <= S_EN_SQ;
        S_EN_SQ: begin
          prod_q  <= ACC_W'(mul_p);
          state_q <= S_EN_FAC;
        end
        S_EN_FAC: begin
          // k^2 at or above one wipes out the prediction error
          if (|prod_q[ACC_W-1:2*FS]) begin
            energy_q <= '0;
            failed_q <= 1'b1;
            state_q  <= S_NEXT;
          end else begin
            fac_q   <= FAC_W'(1 << FS) - FAC_W'(prod_q[2*FS-1:FS]);
            state_q <= S_EN_MUL;
          end
        end
        S_EN_MUL: begin
          prod_q    <= ACC_W'(mul_p);
          lo_prod_q <= energy_q[15:0] * fac_q;
          state_q   <= S_EN_UPD;
        end
        S_EN_UPD: begin
          energy_q <= e_sum[E_W+10:11];
          if (e_sum[ACC_W-1:11] == '0) begin
            failed_q <= 1'b1;
          end
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (i_q == ord) begin
            i_q     <= IDX_W'(1);
            state_q <= S_EMIT_RD;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_STAGE;
          end
        end
        S_EMIT_RD: state_q <= S_EMIT_LD;
        S_EMIT_LD: begin
          // hold the read until the output register frees up
          if (out_free) begin
            out_valid_q  <= 1'b1;
            coef_index_q <= lds_pkg::ORDER_W'(i_q);
            coef_value_q <= neg_coef;
            reflection_q <= refl_rd_q;
            status_q     <= failed_q ? lds_pkg::STATUS_FAIL : lds_pkg::STATUS_OK;
            last_q       <= (i_q == ord);
            if (i_q == ord) begin
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coef_index_o  = coef_index_q;
  assign coef_value_o  = coef_value_q;
  assign reflection_o  = reflection_q;
  assign status_o      = status_q;
  assign last_result_o = last_q;

endmodule

/* rtl/lds_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reflection coefficient divider
// Restoring divider: num * 2^24 / den, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module lds_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lds_pkg::div_req_t                   req_i,
  input  logic [lds_pkg::ENERGY_W-1:0]        den_i,
  output lds_pkg::div_rsp_t                   rsp_o
);

  localparam int MAG_W = lds_pkg::MAG_W;
  localparam int DSH_W = lds_pkg::ENERGY_W + lds_pkg::DIV_INT_STEPS - 1;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e                        state_q;
  logic                              neg_q;
  logic [MAG_W-1:0]                  rem_q;
  logic [DSH_W-1:0]                  dsh_q;
  logic [lds_pkg::QUO_W-1:0]         quo_bits_q;
  logic [lds_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic                              done_q;
  logic signed [lds_pkg::COEF_W-1:0] quo_q;

  logic [lds_pkg::ACC_W-1:0] abs_num;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          sat_lim;
  logic                      int_phase;
  logic [MAG_W-1:0]          trial;
  logic [MAG_W-1:0]          den_sel;
  logic                      ge;
  logic [lds_pkg::QUO_W-1:0] quo_bits_d;

  always_comb begin
    abs_num    = req_i.num[lds_pkg::ACC_W-1] ? lds_pkg::ACC_W'(-req_i.num) : req_i.num;
    mag        = abs_num[MAG_W-1:0];
    sat_lim    = MAG_W'({den_i, {lds_pkg::DIV_INT_STEPS{1'b0}}});
    int_phase  = (cnt_q < lds_pkg::DIV_CNT_W'(lds_pkg::DIV_INT_STEPS));
    trial      = int_phase ? rem_q : {rem_q[MAG_W-2:0], 1'b0};
    den_sel    = int_phase ? MAG_W'(dsh_q) : MAG_W'(den_i);
    ge         = (trial >= den_sel);
    quo_bits_d = {quo_bits_q[lds_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DIV_IDLE: begin
          if (req_i.start) begin
            neg_q <= req_i.num[lds_pkg::ACC_W-1];
            if (mag >= sat_lim) begin
              // quotient would need eight integer bits: clamp
              quo_q  <= req_i.num[lds_pkg::ACC_W-1] ? lds_pkg::COEF_MIN : lds_pkg::COEF_MAX;
              done_q <= 1'b1;
            end else begin
              rem_q      <= mag;
              dsh_q      <= {den_i, {(lds_pkg::DIV_INT_STEPS-1){1'b0}}};
              quo_bits_q <= '0;
              cnt_q      <= '0;
              state_q    <= DIV_RUN;
            end
          end
        end
        DIV_RUN: begin
          rem_q      <= ge ? (trial - den_sel) : trial;
          dsh_q      <= dsh_q >> 1;
          quo_bits_q <= quo_bits_d;
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == lds_pkg::DIV_CNT_W'(lds_pkg::DIV_STEPS - 1)) begin
            quo_q   <= neg_q ? -$signed({1'b0, quo_bits_d}) : $signed({1'b0, quo_bits_d});
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
